// ===== hdl/dahs_pkg.sv =====
package dahs_pkg;

	localparam int SAMPLE_DEPTH_DEF  = 64;
	localparam int HISTORY_DEPTH_DEF = 128;
	localparam int RECENT_COUNT_DEF  = 10;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 8;
	localparam int TREND_W  = 2;

	typedef enum logic [TREND_W-1:0] {
		TREND_FLAT  = 2'd0,
		TREND_ABOVE = 2'd1,
		TREND_BELOW = 2'd2
	} trend_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       period_elapsed;
	} in_item_t;

	typedef struct packed {
		logic                       pushed;
		logic signed [SAMPLE_W-1:0] decimated_value;
		logic [COUNT_W-1:0]         history_count;
		logic signed [SAMPLE_W-1:0] history_mean;
		logic signed [SAMPLE_W-1:0] history_min;
		logic signed [SAMPLE_W-1:0] history_max;
		logic [SAMPLE_W-1:0]        history_spread;
		logic [TREND_W-1:0]         trend_code;
	} out_item_t;

endpackage

// ===== hdl/dahs_stream_if.sv =====
interface dahs_stream_if #(
	parameter int W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/dahs_divider.sv =====
module dahs_divider #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] numer,
	input  logic [DW-1:0]        denom,
	output logic                 done,
	output logic signed [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q[DW-1:0], num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				neg_q  <= numer[NW-1];
				num_q  <= numer[NW-1] ? NW'(-numer) : numer;
				den_q  <= denom;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (!diff[DW]) begin
					rem_q <= diff;
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					num_q <= {num_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quot = neg_q ? -$signed(num_q) : $signed(num_q);
endmodule

// ===== hdl/dahs_front.sv =====
module dahs_front #(
	parameter int SAMPLE_DEPTH = dahs_pkg::SAMPLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	dahs_stream_if.sink                         in_ch,
	output logic                                q_valid,
	input  logic                                q_ready,
	output logic                                q_push,
	output logic signed [dahs_pkg::SAMPLE_W-1:0] q_avg
);
	localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int FW = $clog2(SAMPLE_DEPTH + 1);
	localparam int SW = dahs_pkg::SAMPLE_W + FW + 1;

	typedef enum logic [1:0] {F_IDLE, F_SUM, F_DIV, F_OUT} fstate_t;

	dahs_pkg::in_item_t item;
	logic signed [dahs_pkg::SAMPLE_W-1:0] ring [SAMPLE_DEPTH];
	logic signed [dahs_pkg::SAMPLE_W-1:0] rd_s1;
	fstate_t       state_q;
	logic [AW-1:0] wpos_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] idx_q;
	logic          rdv_s1;
	logic signed [SW-1:0] sum_q;
	logic          div_start;
	logic          div_done;
	logic signed [SW-1:0] div_quot;
	logic [FW-1:0] nfill;

	assign item = in_ch.data;
	assign in_ch.ready = (state_q == F_IDLE) && !q_valid;
	assign nfill = (fill_q < FW'(SAMPLE_DEPTH)) ? fill_q + 1'b1 : fill_q;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			ring[wpos_q] <= item.sample;
		rd_s1 <= ring[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			wpos_q    <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			rdv_s1    <= 1'b0;
			q_valid   <= 1'b0;
			q_push    <= 1'b0;
			div_start <= 1'b0;
		end else begin
			div_start <= 1'b0;
			if (q_valid && q_ready)
				q_valid <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (item.period_elapsed) begin
							fill_q  <= nfill;
							idx_q   <= '0;
							sum_q   <= '0;
							rdv_s1  <= 1'b0;
							state_q <= F_SUM;
						end else begin
							fill_q  <= nfill;
							wpos_q  <= (wpos_q == AW'(SAMPLE_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
							q_push  <= 1'b0;
							q_avg   <= '0;
							q_valid <= 1'b1;
						end
					end
				end
				F_SUM: begin
					if (rdv_s1)
						sum_q <= sum_q + SW'(rd_s1);
					if (idx_q < fill_q) begin
						idx_q  <= idx_q + 1'b1;
						rdv_s1 <= 1'b1;
					end else begin
						rdv_s1 <= 1'b0;
						if (!rdv_s1) begin
							div_start <= 1'b1;
							state_q   <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (div_done) begin
						q_avg   <= div_quot[dahs_pkg::SAMPLE_W-1:0];
						q_push  <= 1'b1;
						q_valid <= 1'b1;
						wpos_q  <= '0;
						fill_q  <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	dahs_divider #(.NW(SW), .DW(FW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(sum_q),
		.denom(fill_q), .done(div_done), .quot(div_quot)
	);
endmodule

// ===== hdl/dahs_back.sv =====
module dahs_back #(
	parameter int HISTORY_DEPTH = dahs_pkg::HISTORY_DEPTH_DEF,
	parameter int RECENT_COUNT  = dahs_pkg::RECENT_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  logic                                 q_push,
	input  logic signed [dahs_pkg::SAMPLE_W-1:0] q_avg,
	dahs_stream_if.source                        out_ch
);
	localparam int SWD = dahs_pkg::SAMPLE_W;
	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int FW  = $clog2(HISTORY_DEPTH + 1);
	localparam int TW  = SWD + FW + 1;
	localparam int RW  = SWD + $clog2(RECENT_COUNT + 1) + 1;
	localparam int PW  = TW + FW + 8;

	typedef enum logic [2:0] {B_IDLE, B_SCAN, B_DIV, B_MUL, B_OUT} bstate_t;

	dahs_pkg::out_item_t res;
	logic signed [SWD-1:0] hist [HISTORY_DEPTH];
	logic signed [SWD-1:0] rd_s1;
	bstate_t       state_q;
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] idx_q;
	logic          rdv_s1;
	logic          recv_s1;
	logic          pushed_q;
	logic signed [TW-1:0]  tot_q;
	logic signed [RW-1:0]  rec_q;
	logic signed [SWD-1:0] lo_q, hi_q, mean_q, avg_q;
	logic [dahs_pkg::TREND_W-1:0] trend_q;
	logic signed [PW-1:0]  lhs_q, rhs_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [AW:0]   rd_sum;
	logic          div_start, div_done;
	logic signed [TW-1:0] div_quot;

	assign q_ready = (state_q == B_IDLE) && !out_ch.valid;
	assign wr_en   = q_valid && q_ready && q_push;
	assign wr_addr = (head_q == '0) ? AW'(HISTORY_DEPTH - 1) : head_q - 1'b1;
	assign rd_sum  = {1'b0, head_q} + (AW+1)'(idx_q);
	assign rd_addr = (rd_sum >= (AW+1)'(HISTORY_DEPTH)) ?
		AW'(rd_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(rd_sum);

	always_ff @(posedge clk) begin
		if (wr_en)
			hist[wr_addr] <= q_avg;
		rd_s1 <= hist[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			head_q       <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			rdv_s1       <= 1'b0;
			recv_s1      <= 1'b0;
			pushed_q     <= 1'b0;
			mean_q       <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			trend_q      <= dahs_pkg::TREND_FLAT;
			out_ch.valid <= 1'b0;
			div_start    <= 1'b0;
		end else begin
			div_start <= 1'b0;
			if (out_ch.valid && out_ch.ready)
				out_ch.valid <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_valid && q_ready) begin
						if (q_push) begin
							avg_q  <= q_avg;
							head_q <= wr_addr;
							if (fill_q < FW'(HISTORY_DEPTH))
								fill_q <= fill_q + 1'b1;
							idx_q   <= '0;
							rdv_s1  <= 1'b0;
							tot_q   <= '0;
							rec_q   <= '0;
							lo_q    <= q_avg;
							hi_q    <= q_avg;
							state_q <= B_SCAN;
						end else begin
							avg_q        <= '0;
							pushed_q     <= 1'b0;
							out_ch.valid <= 1'b1;
						end
					end
				end
				B_SCAN: begin
					if (rdv_s1) begin
						tot_q <= tot_q + TW'(rd_s1);
						if (recv_s1)
							rec_q <= rec_q + RW'(rd_s1);
						if (rd_s1 < lo_q) lo_q <= rd_s1;
						if (rd_s1 > hi_q) hi_q <= rd_s1;
					end
					if (idx_q < fill_q) begin
						recv_s1 <= 32'(idx_q) < RECENT_COUNT;
						idx_q   <= idx_q + 1'b1;
						rdv_s1  <= 1'b1;
					end else begin
						rdv_s1 <= 1'b0;
						if (!rdv_s1) begin
							div_start <= 1'b1;
							state_q   <= B_DIV;
						end
					end
				end
				B_DIV: begin
					if (div_done) begin
						mean_q  <= div_quot[SWD-1:0];
						lhs_q   <= PW'(rec_q) * $signed({1'b0, fill_q});
						rhs_q   <= PW'(tot_q) * PW'(RECENT_COUNT);
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (lhs_q > rhs_q)
						trend_q <= dahs_pkg::TREND_ABOVE;
					else if (lhs_q < rhs_q)
						trend_q <= dahs_pkg::TREND_BELOW;
					else
						trend_q <= dahs_pkg::TREND_FLAT;
					state_q <= B_OUT;
				end
				B_OUT: begin
					pushed_q     <= 1'b1;
					out_ch.valid <= 1'b1;
					state_q      <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_ch.data = res;

	assign res.pushed          = pushed_q;
	assign res.decimated_value = avg_q;
	assign res.history_count   = dahs_pkg::COUNT_W'(fill_q);
	assign res.history_mean    = mean_q;
	assign res.history_min     = lo_q;
	assign res.history_max     = hi_q;
	assign res.history_spread  = hi_q - lo_q;
	assign res.trend_code      = trend_q;

	dahs_divider #(.NW(TW), .DW(FW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(tot_q),
		.denom(fill_q), .done(div_done), .quot(div_quot)
	);
endmodule

// ===== hdl/decimating_average_history_stats.sv =====
// A sample without the period flag passes through the queue valid register and then the
// output valid register. A push is held up by the sequential scans of the sample ring and
// of the history memory and by the bit-serial dividers.
// Throughput: one item at a time in each half; the queue lets the halves overlap.
// Reset: arst_n clears the counters and the history mean, min, max and trend at once;
// the running sums, the decimated value and the memories are not cleared.
module decimating_average_history_stats #(
	parameter int SAMPLE_DEPTH  = dahs_pkg::SAMPLE_DEPTH_DEF,
	parameter int HISTORY_DEPTH = dahs_pkg::HISTORY_DEPTH_DEF,
	parameter int RECENT_COUNT  = dahs_pkg::RECENT_COUNT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	dahs_stream_if.sink   in_ch,
	dahs_stream_if.source out_ch
);
	logic q_valid, q_ready, q_push;
	logic signed [dahs_pkg::SAMPLE_W-1:0] q_avg;

	dahs_front #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .q_valid(q_valid),
		.q_ready(q_ready), .q_push(q_push), .q_avg(q_avg)
	);

	dahs_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .RECENT_COUNT(RECENT_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_push(q_push), .q_avg(q_avg), .out_ch(out_ch)
	);

	a_spread: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.data[17:2] == 16'(out_ch.data[33:18] - out_ch.data[49:34])))
		else $error("spread mismatch");
	a_nopush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.data[90]) |-> (out_ch.data[89:74] == '0))
		else $error("value without push");
endmodule

// ===== tb/decimating_average_history_stats_tb.sv =====
`timescale 1ns / 1ps

module decimating_average_history_stats_tb;

	localparam int SDEPTH = dahs_pkg::SAMPLE_DEPTH_DEF;
	localparam int HDEPTH = dahs_pkg::HISTORY_DEPTH_DEF;
	localparam int RCOUNT = dahs_pkg::RECENT_COUNT_DEF;

	// Mirrors the block's sample ring and history and keeps the statistics
	// that each transfer is expected to produce.
	class stats_scoreboard;
		int samples[SDEPTH];
		int wr_pos;
		int fill;
		int hist[HDEPTH];
		int hist_fill;
		int mean_q, min_q, max_q;
		dahs_pkg::trend_t trend_q;
		dahs_pkg::out_item_t pending[$];
		int mismatches;

		function new();
			wr_pos = 0;
			fill = 0;
			hist_fill = 0;
			mean_q = 0;
			min_q = 0;
			max_q = 0;
			trend_q = dahs_pkg::TREND_FLAT;
			mismatches = 0;
		endfunction

		function void note_input(dahs_pkg::in_item_t it);
			dahs_pkg::out_item_t r;
			longint total, recent, lhs, rhs;
			int avg, lo, hi;
			if (fill < SDEPTH) fill++;
			samples[wr_pos] = it.sample;
			wr_pos = (wr_pos + 1) % SDEPTH;
			avg = 0;
			if (it.period_elapsed) begin
				total = 0;
				for (int i = 0; i < fill; i++) total += samples[i];
				avg = int'(total / fill);
				wr_pos = 0;
				fill = 0;
				if (hist_fill < HDEPTH) hist_fill++;
				for (int i = hist_fill - 1; i > 0; i--) hist[i] = hist[i-1];
				hist[0] = avg;
				total = 0;
				recent = 0;
				lo = 32'h7fffffff;
				hi = 32'h80000000;
				for (int i = 0; i < hist_fill; i++) begin
					if (hist[i] > hi) hi = hist[i];
					if (hist[i] < lo) lo = hist[i];
					total += hist[i];
					if (i < RCOUNT) recent += hist[i];
				end
				mean_q = int'(total / hist_fill);
				min_q = lo;
				max_q = hi;
				lhs = recent * hist_fill;
				rhs = total * RCOUNT;
				trend_q = dahs_pkg::TREND_FLAT;
				if (lhs > rhs) trend_q = dahs_pkg::TREND_ABOVE;
				if (lhs < rhs) trend_q = dahs_pkg::TREND_BELOW;
			end
			r.pushed = it.period_elapsed;
			r.decimated_value = avg[15:0];
			r.history_count = hist_fill[7:0];
			r.history_mean = mean_q[15:0];
			r.history_min = min_q[15:0];
			r.history_max = max_q[15:0];
			r.history_spread = 16'(max_q - min_q);
			r.trend_code = trend_q;
			pending.push_back(r);
		endfunction

		function void check_result(dahs_pkg::out_item_t got);
			dahs_pkg::out_item_t exp_r;
			if (pending.size() == 0) begin
				report(got, got, 1);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) report(exp_r, got, 0);
		endfunction

		function void report(dahs_pkg::out_item_t e, dahs_pkg::out_item_t g, bit unexpected);
			mismatches++;
			if (mismatches <= 10) begin
				if (unexpected)
					$display("Unexpected result transfer: %p", g);
				else
					$display("Mismatch: expected %p, got %p", e, g);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	dahs_stream_if #(.W($bits(dahs_pkg::in_item_t))) in_ch();
	dahs_stream_if #(.W($bits(dahs_pkg::out_item_t))) out_ch();

	decimating_average_history_stats DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	stats_scoreboard sb;
	bit sending_done;
	int sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(logic signed [15:0] s, logic pe);
		dahs_pkg::in_item_t it;
		int g;
		g = gap_len();
		if (g != 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		it.sample = s;
		it.period_elapsed = pe;
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_input(it);
		sent++;
	endtask

	task automatic send_burst(int n, int lo, int hi);
		for (int i = 0; i < n; i++)
			send_item(16'($urandom_range(lo, hi) - 32768), 1'b0);
	endtask

	task automatic random_sample(output logic signed [15:0] s);
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) s = 16'sh7fff;
		else if (p == 1) s = 16'sh8000;
		else s = 16'($urandom);
	endtask

	initial begin
		logic signed [15:0] s;
		int n;
		sb = new();
		sending_done = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(16'sh7fff, 1'b0);
		send_item(16'sh7fff, 1'b1);
		send_item(16'sh8000, 1'b1);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh0001, 1'b1);
		send_item(-16'sd7, 1'b0);
		send_item(16'sd2, 1'b1);
		send_item(16'sd5, 1'b0);
		send_item(16'sh5555, 1'b0);
		send_item(16'shaaaa, 1'b0);
		send_item(16'sd0, 1'b1);
		send_burst(70, 0, 65535);
		send_item(16'sd3, 1'b1);
		while (sent < 1300) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 6);
			for (int i = 0; i < n; i++) begin
				random_sample(s);
				send_item(s, 1'b0);
			end
			random_sample(s);
			send_item(s, 1'b1);
		end
		in_ch.valid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin
		int g;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g != 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(dahs_pkg::out_item_t'(out_ch.data));
		end
	end

	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
